@@ src/nearest_rect_or_point_search_unit_macros.svh @@
// ----------------------------------------------------------------------------
// nearest rect or point search unit: assertion macros
// wrappers for concurrent checks, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef NEAREST_RECT_OR_POINT_SEARCH_UNIT_MACROS_SVH
`define NEAREST_RECT_OR_POINT_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NRPS_ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("nrps check failed");
// next-cycle implication
`define NRPS_ASSERT_NXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("nrps check failed");
`else
`define NRPS_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define NRPS_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

@@ src/nrps_pkg.sv @@
// ----------------------------------------------------------------------------
// nrps_pkg
// shared widths, codes and stage types of the nearest point search
// ----------------------------------------------------------------------------
package nrps_pkg;

	localparam int COORD_W     = 32;
	localparam int DIST_W      = 37;
	localparam int KIND_W      = 2;
	localparam int WEIGHT_W    = 16;
	localparam int FRAC_W      = 12;
	localparam int PROD_W      = WEIGHT_W + COORD_W;
	localparam int WY_W        = PROD_W - FRAC_W;
	localparam int S_TDATA_W   = 6 * COORD_W;
	localparam int M_TDATA_W   = ((DIST_W + 2 * COORD_W + 7) / 8) * 8;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(4096);

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BOX  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TERM = 2'd2;

	typedef logic [KIND_W-1:0]         kind_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [DIST_W-1:0]         dist_t;

	// candidate leaving the distance pipeline
	typedef struct packed {
		logic   valid;
		logic   cand;
		logic   last;
		kind_t  kind;
		dist_t  distance;
		coord_t px;
		coord_t py;
	} cand_t;

	// finished query result
	typedef struct packed {
		logic   valid;
		dist_t  distance;
		coord_t x;
		coord_t y;
		kind_t  kind;
	} result_t;

endpackage

@@ src/nrps_geom_pipe.sv @@
// ----------------------------------------------------------------------------
// nrps_geom_pipe
// five-stage pipeline from one entry to its weighted distance and point
// ----------------------------------------------------------------------------
module nrps_geom_pipe (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  nrps_pkg::kind_t                     in_kind,
	input  logic                                in_last,
	input  nrps_pkg::coord_t                    in_xl,
	input  nrps_pkg::coord_t                    in_yl,
	input  nrps_pkg::coord_t                    in_xh,
	input  nrps_pkg::coord_t                    in_yh,
	input  nrps_pkg::coord_t                    in_px,
	input  nrps_pkg::coord_t                    in_py,
	input  logic [nrps_pkg::WEIGHT_W-1:0]       weight,
	output nrps_pkg::cand_t                     cand
);

	localparam int CW = nrps_pkg::COORD_W;

	// stage valids and tags
	logic [4:0] v_q;
	logic       cand_s1, cand_s2, cand_s3, cand_s4, cand_s5;
	logic       last_s1, last_s2, last_s3, last_s4, last_s5;
	nrps_pkg::kind_t kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;

	// s1: raw entry
	nrps_pkg::coord_t xl_s1, yl_s1, xh_s1, yh_s1, px_s1, py_s1;
	// s2: ordered intervals
	nrps_pkg::coord_t xlo_s2, xhi_s2, ylo_s2, yhi_s2, px_s2, py_s2;
	// s3: gaps and clamped point
	logic [CW-1:0]    dx_s3, dy_s3;
	nrps_pkg::coord_t cx_s3, cy_s3;
	// s4: weighted vertical product
	logic [CW-1:0]    dx_s4;
	logic [nrps_pkg::PROD_W-1:0] prod_s4;
	nrps_pkg::coord_t cx_s4, cy_s4;
	// s5: distance
	nrps_pkg::dist_t  dist_s5;
	nrps_pkg::coord_t cx_s5, cy_s5;

	// s1 -> s2 ordering
	logic             is_box_s1;
	nrps_pkg::coord_t xlo_c, xhi_c, ylo_c, yhi_c;

	// s2 -> s3 gap logic
	logic [CW:0]      x_below, x_above, y_below, y_above;
	logic [CW-1:0]    dx_c, dy_c;
	nrps_pkg::coord_t cx_c, cy_c;

	// s4 -> s5 rounding
	logic [nrps_pkg::PROD_W-1:0] rnd_c;

	always_comb begin
		is_box_s1 = (kind_s1 == nrps_pkg::KIND_BOX);
		if (is_box_s1 && ($signed(xl_s1) > $signed(xh_s1))) begin
			xlo_c = xh_s1;
			xhi_c = xl_s1;
		end else begin
			xlo_c = xl_s1;
			xhi_c = is_box_s1 ? xh_s1 : xl_s1;
		end
		if (is_box_s1 && ($signed(yl_s1) > $signed(yh_s1))) begin
			ylo_c = yh_s1;
			yhi_c = yl_s1;
		end else begin
			ylo_c = yl_s1;
			yhi_c = is_box_s1 ? yh_s1 : yl_s1;
		end
	end

	always_comb begin
		x_below = {xlo_s2[CW-1], xlo_s2} - {px_s2[CW-1], px_s2};
		x_above = {px_s2[CW-1], px_s2} - {xhi_s2[CW-1], xhi_s2};
		y_below = {ylo_s2[CW-1], ylo_s2} - {py_s2[CW-1], py_s2};
		y_above = {py_s2[CW-1], py_s2} - {yhi_s2[CW-1], yhi_s2};
		if ($signed(px_s2) < $signed(xlo_s2)) begin
			dx_c = x_below[CW-1:0];
			cx_c = xlo_s2;
		end else if ($signed(px_s2) > $signed(xhi_s2)) begin
			dx_c = x_above[CW-1:0];
			cx_c = xhi_s2;
		end else begin
			dx_c = '0;
			cx_c = px_s2;
		end
		if ($signed(py_s2) < $signed(ylo_s2)) begin
			dy_c = y_below[CW-1:0];
			cy_c = ylo_s2;
		end else if ($signed(py_s2) > $signed(yhi_s2)) begin
			dy_c = y_above[CW-1:0];
			cy_c = yhi_s2;
		end else begin
			dy_c = '0;
			cy_c = py_s2;
		end
	end

	// round half up before dropping the fraction
	assign rnd_c = prod_s4 + nrps_pkg::PROD_W'(2048);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= in_kind;
			last_s1 <= in_last;
			cand_s1 <= (in_kind == nrps_pkg::KIND_BOX) || (in_kind == nrps_pkg::KIND_TERM);
			xl_s1   <= in_xl;
			yl_s1   <= in_yl;
			xh_s1   <= in_xh;
			yh_s1   <= in_yh;
			px_s1   <= in_px;
			py_s1   <= in_py;

			kind_s2 <= kind_s1;
			last_s2 <= last_s1;
			cand_s2 <= cand_s1;
			xlo_s2  <= xlo_c;
			xhi_s2  <= xhi_c;
			ylo_s2  <= ylo_c;
			yhi_s2  <= yhi_c;
			px_s2   <= px_s1;
			py_s2   <= py_s1;

			kind_s3 <= kind_s2;
			last_s3 <= last_s2;
			cand_s3 <= cand_s2;
			dx_s3   <= dx_c;
			dy_s3   <= dy_c;
			cx_s3   <= cx_c;
			cy_s3   <= cy_c;

			kind_s4 <= kind_s3;
			last_s4 <= last_s3;
			cand_s4 <= cand_s3;
			dx_s4   <= dx_s3;
			prod_s4 <= nrps_pkg::PROD_W'(weight) * nrps_pkg::PROD_W'(dy_s3);
			cx_s4   <= cx_s3;
			cy_s4   <= cy_s3;

			kind_s5 <= kind_s4;
			last_s5 <= last_s4;
			cand_s5 <= cand_s4;
			dist_s5 <= nrps_pkg::DIST_W'(dx_s4)
				+ nrps_pkg::DIST_W'(rnd_c[nrps_pkg::PROD_W-1:nrps_pkg::FRAC_W]);
			cx_s5   <= cx_s4;
			cy_s5   <= cy_s4;
		end
	end

	always_comb begin
		cand.valid    = v_q[4];
		cand.cand     = cand_s5;
		cand.last     = last_s5;
		cand.kind     = kind_s5;
		cand.distance = dist_s5;
		cand.px       = cx_s5;
		cand.py       = cy_s5;
	end

endmodule

@@ src/nrps_best_track.sv @@
// ----------------------------------------------------------------------------
// nrps_best_track
// running best of one query, emits the result on the last entry
// ----------------------------------------------------------------------------
module nrps_best_track (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  nrps_pkg::cand_t   cand,
	output nrps_pkg::result_t res
);

	logic             best_valid_q;
	nrps_pkg::dist_t  best_dist_q;
	nrps_pkg::coord_t best_px_q;
	nrps_pkg::coord_t best_py_q;
	nrps_pkg::kind_t  best_kind_q;

	logic             step;
	logic             beats;
	logic             take_cand;
	logic             m_valid;
	nrps_pkg::dist_t  m_dist;
	nrps_pkg::coord_t m_px;
	nrps_pkg::coord_t m_py;
	nrps_pkg::kind_t  m_kind;

	assign step = en && cand.valid;

	// distance, then x, then y, then terminal before box
	always_comb begin
		if (!best_valid_q) begin
			beats = 1'b1;
		end else if (cand.distance != best_dist_q) begin
			beats = cand.distance < best_dist_q;
		end else if (cand.px != best_px_q) begin
			beats = $signed(cand.px) < $signed(best_px_q);
		end else if (cand.py != best_py_q) begin
			beats = $signed(cand.py) < $signed(best_py_q);
		end else begin
			beats = cand.kind > best_kind_q;
		end
		take_cand = cand.cand && beats;
		m_valid   = best_valid_q || cand.cand;
		m_dist    = take_cand ? cand.distance : best_dist_q;
		m_px      = take_cand ? cand.px   : best_px_q;
		m_py      = take_cand ? cand.py   : best_py_q;
		m_kind    = take_cand ? cand.kind : best_kind_q;
	end

	always_comb begin
		res.valid = step && cand.last;
		if (m_valid) begin
			res.distance = m_dist;
			res.x        = m_px;
			res.y        = m_py;
			res.kind     = m_kind;
		end else begin
			res.distance = '1;
			res.x        = '0;
			res.y        = '0;
			res.kind     = nrps_pkg::KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			best_dist_q  <= '0;
			best_px_q    <= '0;
			best_py_q    <= '0;
			best_kind_q  <= nrps_pkg::KIND_NONE;
		end else if (step) begin
			if (cand.last) begin
				best_valid_q <= 1'b0;
				best_dist_q  <= '0;
				best_px_q    <= '0;
				best_py_q    <= '0;
				best_kind_q  <= nrps_pkg::KIND_NONE;
			end else begin
				best_valid_q <= m_valid;
				best_dist_q  <= m_dist;
				best_px_q    <= m_px;
				best_py_q    <= m_py;
				best_kind_q  <= m_kind;
			end
		end
	end

endmodule

@@ src/nearest_rect_or_point_search_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_rect_or_point_search_unit
// streams boxes and terminals of one subnet, reports the one nearest the pin
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         entries: kind in tuser, end of query in tlast
//  m_axis    out        one result per query, kind in tuser
//  cfg       in         vertical weight, Q4.12, write only
//
//  one entry per cycle while s_axis_tready is high; five pipeline stages before the
//  running best, whose compare against the new candidate is combinational
//  the result is registered into the output buffer on its way to m_axis
//  a two-entry output buffer decouples the sides; s_axis_tready drops only
//  while both entries hold results that the sink has not taken
//  reset clears the pipeline, the running best and the output buffer, and
//  sets the weight to 1.0
// ----------------------------------------------------------------------------
`include "nearest_rect_or_point_search_unit_macros.svh"

module nearest_rect_or_point_search_unit (
	input  logic                              clk,
	input  logic                              arst_n,

	// entry stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// x_low, y_low, x_high, y_high, pin_x, pin_y
	input  logic [nrps_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// entry_kind
	input  logic [nrps_pkg::KIND_W-1:0]       s_axis_tuser,
	input  logic                              s_axis_tlast,

	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// best_distance, nearest_x, nearest_y, zero fill
	output logic [nrps_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// nearest_kind
	output logic [nrps_pkg::KIND_W-1:0]       m_axis_tuser,

	// vertical weight register
	input  logic                              cfg_we,
	input  logic [nrps_pkg::WEIGHT_W-1:0]     cfg_wdata
);

	localparam int CW  = nrps_pkg::COORD_W;
	localparam int PAD = nrps_pkg::M_TDATA_W - nrps_pkg::DIST_W - 2 * CW;

	logic [nrps_pkg::WEIGHT_W-1:0] weight_q;

	// output buffer: head register plus one skid entry
	logic              out_valid_q;
	logic              skid_valid_q;
	nrps_pkg::result_t out_q;
	nrps_pkg::result_t skid_q;

	logic              en;
	logic              take;
	nrps_pkg::cand_t   cand;
	nrps_pkg::result_t res;

	// the pipeline moves whenever the skid entry is free
	assign en            = !skid_valid_q;
	assign s_axis_tready = en;
	assign take          = out_valid_q && m_axis_tready;

	// weight register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= nrps_pkg::WEIGHT_RESET;
		end else if (cfg_we) begin
			weight_q <= cfg_wdata;
		end
	end

	nrps_geom_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_last  (s_axis_tlast),
		.in_xl    (s_axis_tdata[CW-1:0]),
		.in_yl    (s_axis_tdata[2*CW-1:CW]),
		.in_xh    (s_axis_tdata[3*CW-1:2*CW]),
		.in_yh    (s_axis_tdata[4*CW-1:3*CW]),
		.in_px    (s_axis_tdata[5*CW-1:4*CW]),
		.in_py    (s_axis_tdata[6*CW-1:5*CW]),
		.weight   (weight_q),
		.cand     (cand)
	);

	nrps_best_track u_best (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cand   (cand),
		.res    (res)
	);

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res.valid) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			// skid entry moves up, or the head empties
			out_valid_q  <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (res.valid) begin
			if (!out_valid_q || take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD{1'b0}}, out_q.y, out_q.x, out_q.distance};
	assign m_axis_tuser  = out_q.kind;

	// a result never arrives while the skid entry is full
	`NRPS_ASSERT_IMP(a_no_skid_overflow, clk, arst_n, res.valid, !skid_valid_q)
	// the skid entry only holds data behind a held head
	`NRPS_ASSERT_IMP(a_skid_behind_head, clk, arst_n, skid_valid_q, out_valid_q)
	// a result into a stalled full head lands in the skid entry
	`NRPS_ASSERT_NXT(a_stall_fills_skid, clk, arst_n, res.valid && out_valid_q && !take,
		skid_valid_q)
	// kind none goes with the saturated distance and nothing else
	`NRPS_ASSERT_IMP(a_none_saturated, clk, arst_n, out_valid_q,
		(out_q.kind == nrps_pkg::KIND_NONE) == (out_q.distance == {nrps_pkg::DIST_W{1'b1}}))

endmodule

@@ verif/tb_nearest_rect_or_point_search_unit.sv @@
// ----------------------------------------------------------------------------
// tb_nearest_rect_or_point_search_unit
// self-checking bench for the nearest box or terminal search: entries stream in
// with random gaps, results are drained with random back-pressure and matched
// in order against a weighted Manhattan predictor kept inside the bench
// ----------------------------------------------------------------------------
module tb_nearest_rect_or_point_search_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// unused kind code, the block treats it like an empty marker
	localparam nrps_pkg::kind_t  KIND_SPARE    = 2'd3;
	localparam int               IDLE_PCT      = 17;
	localparam int               PHASE_ITEMS   = 160;
	localparam int               PAUSE_EVERY   = 70;
	localparam int               SETTLE_CYCLES = 12;
	localparam int               CYCLE_LIMIT   = 200000;
	localparam int               REPORT_MAX    = 10;
	localparam nrps_pkg::dist_t  DIST_NONE     = '1;
	localparam nrps_pkg::coord_t COORD_MIN     = 32'sh8000_0000;
	localparam nrps_pkg::coord_t COORD_MAX     = 32'sh7FFF_FFFF;
	localparam int               FILL_W        =
		nrps_pkg::M_TDATA_W - nrps_pkg::DIST_W - 2 * nrps_pkg::COORD_W;

	// one entry of a query, as driven on s_axis
	typedef struct {
		nrps_pkg::kind_t  kind;
		nrps_pkg::coord_t xl;
		nrps_pkg::coord_t yl;
		nrps_pkg::coord_t xh;
		nrps_pkg::coord_t yh;
		nrps_pkg::coord_t px;
		nrps_pkg::coord_t py;
		logic             last;
	} entry_t;

	// one query answer, as expected on m_axis
	typedef struct {
		nrps_pkg::dist_t  distance;
		nrps_pkg::coord_t x;
		nrps_pkg::coord_t y;
		nrps_pkg::kind_t  kind;
	} answer_t;

	// running nearest point per query, plus the answers still owed by the block
	class nearest_point_tracker;
		logic [nrps_pkg::WEIGHT_W-1:0] weight;
		bit                            have_best;
		nrps_pkg::dist_t               best_dist;
		longint                        best_x;
		longint                        best_y;
		nrps_pkg::kind_t               best_kind;
		answer_t                       pending_nearest[$];
		int                            errors;

		function new();
			weight    = nrps_pkg::WEIGHT_RESET;
			have_best = 1'b0;
			errors    = 0;
		endfunction

		// distance from p to the interval [lo, hi]
		function longint unsigned gap(longint p, longint lo, longint hi);
			if (p < lo)
				return lo - p;
			if (p > hi)
				return p - hi;
			return 0;
		endfunction

		// fold one accepted entry into the running best, close the query on last
		function void take_entry(entry_t e);
			longint            xl, yl, xh, yh, px, py, cx, cy, t;
			longint unsigned   gx, gy, wy;
			nrps_pkg::dist_t   d;
			answer_t           a;
			xl = e.xl;
			yl = e.yl;
			xh = e.xh;
			yh = e.yh;
			px = e.px;
			py = e.py;
			if (e.kind == nrps_pkg::KIND_BOX || e.kind == nrps_pkg::KIND_TERM) begin
				if (e.kind == nrps_pkg::KIND_BOX) begin
					// a reversed box is used with its corners swapped per axis
					if (xl > xh) begin
						t = xl; xl = xh; xh = t;
					end
					if (yl > yh) begin
						t = yl; yl = yh; yh = t;
					end
					gx = gap(px, xl, xh);
					gy = gap(py, yl, yh);
					cx = px < xl ? xl : (px > xh ? xh : px);
					cy = py < yl ? yl : (py > yh ? yh : py);
				end else begin
					gx = gap(px, xl, xl);
					gy = gap(py, yl, yl);
					cx = xl;
					cy = yl;
				end
				// vertical gap times Q4.12 weight, rounded half up
				wy = ({48'd0, weight} * gy + 64'd2048) >> nrps_pkg::FRAC_W;
				d  = nrps_pkg::dist_t'(gx + wy);
				if (!have_best || d < best_dist ||
				    (d == best_dist && (cx < best_x ||
				    (cx == best_x && (cy < best_y ||
				    (cy == best_y && e.kind > best_kind)))))) begin
					have_best = 1'b1;
					best_dist = d;
					best_x    = cx;
					best_y    = cy;
					best_kind = e.kind;
				end
			end
			if (e.last) begin
				if (have_best) begin
					a.distance = best_dist;
					a.x        = nrps_pkg::coord_t'(best_x);
					a.y        = nrps_pkg::coord_t'(best_y);
					a.kind     = best_kind;
				end else begin
					a.distance = DIST_NONE;
					a.x        = '0;
					a.y        = '0;
					a.kind     = nrps_pkg::KIND_NONE;
				end
				pending_nearest.insert(pending_nearest.size(), a);
				have_best = 1'b0;
			end
		endfunction

		// compare one result transfer with the oldest owed answer
		function void check_result(logic [nrps_pkg::M_TDATA_W-1:0] data,
				nrps_pkg::kind_t kind);
			answer_t           a;
			nrps_pkg::dist_t   d;
			nrps_pkg::coord_t  x, y;
			logic [FILL_W-1:0] fill;
			d    = data[nrps_pkg::DIST_W-1:0];
			x    = data[nrps_pkg::DIST_W +: nrps_pkg::COORD_W];
			y    = data[nrps_pkg::DIST_W + nrps_pkg::COORD_W +: nrps_pkg::COORD_W];
			fill = data[nrps_pkg::M_TDATA_W-1 -: FILL_W];
			if (pending_nearest.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result: dist %0d x %0d y %0d kind %0d",
						d, x, y, kind);
				return;
			end
			a = pending_nearest.pop_front();
			if (d !== a.distance || x !== a.x || y !== a.y || kind !== a.kind ||
			    fill !== '0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display({"mismatch: expected dist %0d x %0d y %0d kind %0d, ",
						"got dist %0d x %0d y %0d kind %0d fill %0h"},
						a.distance, a.x, a.y, a.kind, d, x, y, kind, fill);
			end
		endfunction
	endclass

	logic                             clk            = 1'b0;
	logic                             arst_n         = 1'b0;
	logic                             s_axis_tvalid  = 1'b0;
	logic                             s_axis_tready;
	// x_low, y_low, x_high, y_high, pin_x, pin_y
	logic [nrps_pkg::S_TDATA_W-1:0]   s_axis_tdata   = '0;
	// entry_kind
	logic [nrps_pkg::KIND_W-1:0]      s_axis_tuser   = '0;
	logic                             s_axis_tlast   = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready  = 1'b0;
	// best_distance, nearest_x, nearest_y, zero fill
	logic [nrps_pkg::M_TDATA_W-1:0]   m_axis_tdata;
	// nearest_kind
	logic [nrps_pkg::KIND_W-1:0]      m_axis_tuser;
	logic                             cfg_we         = 1'b0;
	logic [nrps_pkg::WEIGHT_W-1:0]    cfg_wdata      = '0;

	nearest_point_tracker   tracker;
	bit                     quiet          = 1'b0;
	int                     cycle_count    = 0;

	nearest_rect_or_point_search_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: check each transfer, then pick next cycle's tready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(m_axis_tdata, m_axis_tuser);
		m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	function automatic entry_t mk(nrps_pkg::kind_t k, nrps_pkg::coord_t xl,
			nrps_pkg::coord_t yl, nrps_pkg::coord_t xh, nrps_pkg::coord_t yh,
			nrps_pkg::coord_t px, nrps_pkg::coord_t py, logic last);
		entry_t e;
		e.kind = k;
		e.xl   = xl;
		e.yl   = yl;
		e.xh   = xh;
		e.yh   = yh;
		e.px   = px;
		e.py   = py;
		e.last = last;
		return e;
	endfunction

	// coordinate around a pin: wide, near, tight (for ties) or extreme
	function automatic nrps_pkg::coord_t pick_coord(nrps_pkg::coord_t center, int mode);
		case (mode)
			0: return $urandom;
			1: return center + nrps_pkg::coord_t'($urandom_range(0, 10000)) - 5000;
			2: return center + nrps_pkg::coord_t'($urandom_range(0, 6)) - 3;
			default: begin
				case ($urandom_range(0, 4))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return 0;
					3: return -1;
					default: return center;
				endcase
			end
		endcase
	endfunction

	// one entry transfer, with random idle cycles ahead of it
	task automatic send_entry(input entry_t e);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {e.py, e.px, e.yh, e.xh, e.yl, e.xl};
		s_axis_tuser  <= e.kind;
		s_axis_tlast  <= e.last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.take_entry(e);
	endtask

	// hold the entry side until every owed answer has come back
	task automatic wait_for_answers();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_nearest.size() != 0)
			@(posedge clk);
	endtask

	// full drain: answers back, then let trailing entries leave the pipeline
	task automatic settle();
		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// weight register write, only called once the block is drained
	task automatic write_weight(input logic [nrps_pkg::WEIGHT_W-1:0] w);
		cfg_wdata <= w;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.weight = w;
	endtask

	// hand-picked queries under the reset weight of 1.0
	task automatic directed();
		// lone empty marker: no candidate
		send_entry(mk(nrps_pkg::KIND_NONE, 0, 0, 0, 0, 0, 0, 1'b1));
		// pin inside a box: distance zero, point is the pin
		send_entry(mk(nrps_pkg::KIND_BOX, -10, -10, 10, 10, 3, 4, 1'b1));
		// farthest terminal from the pin
		send_entry(mk(nrps_pkg::KIND_TERM, COORD_MAX, COORD_MAX, 0, 0,
			COORD_MIN, COORD_MIN, 1'b1));
		// reversed box on both axes
		send_entry(mk(nrps_pkg::KIND_BOX, 20, 30, 10, 5, 0, 0, 1'b1));
		// spare kind and empty markers mixed in, query closed by the spare kind
		send_entry(mk(KIND_SPARE, 1, 1, 1, 1, 0, 0, 1'b0));
		send_entry(mk(nrps_pkg::KIND_NONE, 2, 2, 2, 2, 0, 0, 1'b0));
		send_entry(mk(nrps_pkg::KIND_TERM, 7, -2, 0, 0, 0, 0, 1'b0));
		send_entry(mk(KIND_SPARE, 0, 0, 0, 0, 0, 0, 1'b1));
		// same point from a box and a terminal: terminal wins, both orders
		send_entry(mk(nrps_pkg::KIND_BOX, 5, -3, 10, 3, 0, 0, 1'b0));
		send_entry(mk(nrps_pkg::KIND_TERM, 5, 0, 0, 0, 0, 0, 1'b1));
		send_entry(mk(nrps_pkg::KIND_TERM, 5, 0, 0, 0, 0, 0, 1'b0));
		send_entry(mk(nrps_pkg::KIND_BOX, 5, -3, 10, 3, 0, 0, 1'b1));
		// equal distance: smaller x, then smaller y
		send_entry(mk(nrps_pkg::KIND_TERM, 3, 0, 0, 0, 0, 0, 1'b0));
		send_entry(mk(nrps_pkg::KIND_TERM, -3, 0, 0, 0, 0, 0, 1'b1));
		send_entry(mk(nrps_pkg::KIND_TERM, 0, 2, 0, 0, 0, 0, 1'b0));
		send_entry(mk(nrps_pkg::KIND_TERM, 0, -2, 0, 0, 0, 0, 1'b1));
		// pin moves within the query
		send_entry(mk(nrps_pkg::KIND_TERM, 100, 0, 0, 0, 0, 0, 1'b0));
		send_entry(mk(nrps_pkg::KIND_TERM, 100, 0, 0, 0, 90, 0, 1'b1));
		// box spanning the whole plane, pin in a corner
		send_entry(mk(nrps_pkg::KIND_BOX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MIN, 1'b1));
	endtask

	// one random query of one to eight entries
	task automatic run_query(output int count);
		int               n, mode, i, roll;
		nrps_pkg::coord_t pin_x, pin_y;
		entry_t           e;
		n     = $urandom_range(1, 8);
		mode  = $urandom_range(0, 3);
		pin_x = $urandom;
		pin_y = $urandom;
		for (i = 0; i < n; i++) begin
			roll   = $urandom_range(0, 99);
			e.kind = roll < 45 ? nrps_pkg::KIND_BOX : roll < 88 ? nrps_pkg::KIND_TERM :
				roll < 96 ? nrps_pkg::KIND_NONE : KIND_SPARE;
			// occasionally the pin moves mid query
			if ($urandom_range(0, 9) == 0) begin
				pin_x = pick_coord(pin_x, mode);
				pin_y = pick_coord(pin_y, mode);
			end
			e.px = pin_x;
			e.py = pin_y;
			e.xl = pick_coord(pin_x, mode);
			e.yl = pick_coord(pin_y, mode);
			if ($urandom_range(0, 4) == 0) begin
				// free corners, often reversed
				e.xh = pick_coord(pin_x, mode);
				e.yh = pick_coord(pin_y, mode);
			end else begin
				e.xh = e.xl + nrps_pkg::coord_t'(mode == 2 ? $urandom_range(0, 4) :
					$urandom_range(0, 3000));
				e.yh = e.yl + nrps_pkg::coord_t'(mode == 2 ? $urandom_range(0, 4) :
					$urandom_range(0, 3000));
			end
			e.last = (i == n - 1);
			send_entry(e);
		end
		count = n;
	endtask

	initial begin
		logic [nrps_pkg::WEIGHT_W-1:0] weights [6];
		int                            p, sent, got, next_pause;
		tracker    = new();
		weights[0] = 16'd0;
		weights[1] = 16'hFFFF;
		weights[2] = 16'd1;
		weights[3] = 16'd2048;
		weights[4] = nrps_pkg::WEIGHT_W'($urandom_range(0, 65535));
		weights[5] = nrps_pkg::WEIGHT_RESET;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();
		settle();

		// one weight per phase, one phase without any idling on either side
		for (p = 0; p < 6; p++) begin
			write_weight(weights[p]);
			quiet      = (p == 2);
			sent       = 0;
			next_pause = PAUSE_EVERY;
			while (sent < PHASE_ITEMS) begin
				run_query(got);
				sent += got;
				if (sent >= next_pause) begin
					wait_for_answers();
					next_pause += PAUSE_EVERY;
				end
			end
			quiet = 1'b0;
			settle();
		end

		if (tracker.errors == 0 && tracker.pending_nearest.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
